/* hdl/mrd_pkg.sv */
// ----------------------------------------------------------------------------
// mrd_pkg - meter readout deframer package
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package mrd_pkg;

   localparam int MAX_BLOCK_BYTES = 65536;
   localparam int LEAD_DEPTH      = 16;
   localparam int IDENT_LIMIT     = 127;
   localparam int MIN_IDENT_BYTES = 5;

   localparam int BLOCK_CNT_W = $clog2(MAX_BLOCK_BYTES + 1);
   localparam int LEAD_CNT_W  = $clog2(LEAD_DEPTH + 1);
   localparam int LEAD_IDX_W  = (LEAD_DEPTH > 1) ? $clog2(LEAD_DEPTH) : 1;
   localparam int IDENT_CNT_W = $clog2(IDENT_LIMIT + 1);

   localparam logic [7:0] CH_STX   = 8'h02;
   localparam logic [7:0] CH_ETX   = 8'h03;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_SIX   = 8'h36;
   localparam logic [7:0] CH_TILDE = 8'h7E;

   typedef enum logic [1:0] {
      KIND_IDENT   = 2'd0,
      KIND_VERDICT = 2'd1,
      KIND_BLOCK   = 2'd2,
      KIND_ERROR   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_BAD_IDENT   = 2'd1,
      STATUS_BAD_BAUD    = 2'd2,
      STATUS_BLOCK_LARGE = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      PH_WAIT,
      PH_IDENT,
      PH_LEAD,
      PH_BLOCK
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_IDENT,
      ST_VERDICT,
      ST_LEAD_EMIT,
      ST_BLOCK,
      ST_OVERSIZE
   } state_type;

   typedef enum logic [1:0] {
      DSEL_RX,
      DSEL_LEAD,
      DSEL_ZERO
   } data_sel_type;

   typedef struct packed {
      logic         ch_load;
      logic         ident_start;
      logic         ident_take;
      logic         lead_push;
      logic         lead_clear;
      logic         lead_take;
      logic         block_take;
      logic         clear;
      logic         emit;
      kind_type     kind;
      status_type   status;
      data_sel_type data_sel;
      logic         baud_en;
      logic         block_end;
      logic         last;
   } mrd_cmd_type;

   typedef struct packed {
      logic is_slash;
      logic is_lf;
      logic is_crlf;
      logic is_stx;
      logic is_print;
      logic ident_room;
      logic line_bad;
      logic baud_ok;
      logic lead_more;
      logic too_big;
      logic block_full;
      logic saw_etx;
      logic slot_free;
   } mrd_stat_type;

endpackage

/* hdl/mrd_ctrl.sv */
// ----------------------------------------------------------------------------
// mrd_ctrl - deframer controller
// Protocol phase and per-byte sequencing; drives the datapath by commands.
// ----------------------------------------------------------------------------
module mrd_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  mrd_pkg::mrd_stat_type stat,
   output mrd_pkg::mrd_cmd_type  cmd
);

   mrd_pkg::state_type state_ff, state_in;
   mrd_pkg::phase_type phase_ff, phase_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mrd_pkg::ST_IDLE;
         phase_ff <= mrd_pkg::PH_WAIT;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

   assign req_ready = (state_ff == mrd_pkg::ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      cmd          = '0;
      cmd.kind     = mrd_pkg::KIND_IDENT;
      cmd.status   = mrd_pkg::STATUS_OK;
      cmd.data_sel = mrd_pkg::DSEL_ZERO;
      unique case (state_ff)
         mrd_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.ch_load = 1'b1;
               state_in    = mrd_pkg::ST_DECODE;
            end
         end
         mrd_pkg::ST_DECODE: begin
            unique case (phase_ff)
               mrd_pkg::PH_WAIT: begin
                  if (stat.is_slash) begin
                     cmd.ident_start = 1'b1;
                     phase_in        = mrd_pkg::PH_IDENT;
                     state_in        = mrd_pkg::ST_IDENT;
                  end else begin
                     state_in = mrd_pkg::ST_IDLE;
                  end
               end
               mrd_pkg::PH_IDENT: state_in = mrd_pkg::ST_IDENT;
               mrd_pkg::PH_LEAD: begin
                  priority if (stat.is_stx) begin
                     cmd.lead_clear = 1'b1;
                     phase_in       = mrd_pkg::PH_BLOCK;
                     state_in       = mrd_pkg::ST_BLOCK;
                  end else if (stat.is_crlf) begin
                     cmd.lead_push = 1'b1;
                     state_in      = mrd_pkg::ST_IDLE;
                  end else if (stat.is_print) begin
                     state_in = stat.too_big ? mrd_pkg::ST_OVERSIZE
                                             : mrd_pkg::ST_LEAD_EMIT;
                  end else begin
                     cmd.lead_clear = 1'b1;
                     state_in       = mrd_pkg::ST_IDLE;
                  end
               end
               mrd_pkg::PH_BLOCK: state_in = mrd_pkg::ST_BLOCK;
               default: state_in = mrd_pkg::ST_IDLE;
            endcase
         end
         mrd_pkg::ST_IDENT: begin
            if (stat.ident_room) begin
               if (stat.slot_free) begin
                  cmd.ident_take = 1'b1;
                  cmd.emit       = 1'b1;
                  cmd.kind       = mrd_pkg::KIND_IDENT;
                  cmd.data_sel   = mrd_pkg::DSEL_RX;
                  cmd.last       = !stat.is_lf;
                  state_in       = stat.is_lf ? mrd_pkg::ST_VERDICT : mrd_pkg::ST_IDLE;
               end
            end else begin
               state_in = stat.is_lf ? mrd_pkg::ST_VERDICT : mrd_pkg::ST_IDLE;
            end
         end
         mrd_pkg::ST_VERDICT: begin
            if (stat.slot_free) begin
               cmd.emit  = 1'b1;
               cmd.kind  = mrd_pkg::KIND_VERDICT;
               cmd.last  = 1'b1;
               cmd.clear = 1'b1;
               state_in  = mrd_pkg::ST_IDLE;
               priority if (stat.line_bad) begin
                  cmd.status = mrd_pkg::STATUS_BAD_IDENT;
                  phase_in   = mrd_pkg::PH_WAIT;
               end else if (stat.baud_ok) begin
                  cmd.baud_en = 1'b1;
                  phase_in    = mrd_pkg::PH_LEAD;
               end else begin
                  cmd.status = mrd_pkg::STATUS_BAD_BAUD;
                  phase_in   = mrd_pkg::PH_WAIT;
               end
            end
         end
         mrd_pkg::ST_LEAD_EMIT: begin
            if (stat.lead_more) begin
               if (stat.slot_free) begin
                  cmd.lead_take = 1'b1;
                  cmd.emit      = 1'b1;
                  cmd.kind      = mrd_pkg::KIND_BLOCK;
                  cmd.data_sel  = mrd_pkg::DSEL_LEAD;
               end
            end else begin
               cmd.lead_clear = 1'b1;
               phase_in       = mrd_pkg::PH_BLOCK;
               state_in       = mrd_pkg::ST_BLOCK;
            end
         end
         mrd_pkg::ST_BLOCK: begin
            if (stat.slot_free) begin
               cmd.emit = 1'b1;
               cmd.last = 1'b1;
               state_in = mrd_pkg::ST_IDLE;
               priority if (stat.block_full) begin
                  cmd.kind   = mrd_pkg::KIND_ERROR;
                  cmd.status = mrd_pkg::STATUS_BLOCK_LARGE;
                  cmd.clear  = 1'b1;
                  phase_in   = mrd_pkg::PH_WAIT;
               end else if (stat.saw_etx) begin
                  cmd.kind      = mrd_pkg::KIND_BLOCK;
                  cmd.data_sel  = mrd_pkg::DSEL_RX;
                  cmd.block_end = 1'b1;
                  cmd.clear     = 1'b1;
                  phase_in      = mrd_pkg::PH_WAIT;
               end else begin
                  cmd.kind       = mrd_pkg::KIND_BLOCK;
                  cmd.data_sel   = mrd_pkg::DSEL_RX;
                  cmd.block_take = 1'b1;
               end
            end
         end
         mrd_pkg::ST_OVERSIZE: begin
            if (stat.slot_free) begin
               cmd.emit   = 1'b1;
               cmd.kind   = mrd_pkg::KIND_ERROR;
               cmd.status = mrd_pkg::STATUS_BLOCK_LARGE;
               cmd.last   = 1'b1;
               cmd.clear  = 1'b1;
               phase_in   = mrd_pkg::PH_WAIT;
               state_in   = mrd_pkg::ST_IDLE;
            end
         end
         default: state_in = mrd_pkg::ST_IDLE;
      endcase
   end

endmodule

/* hdl/mrd_dp.sv */
// ----------------------------------------------------------------------------
// mrd_dp - deframer datapath
// Byte register, line and block counters, CR/LF lead-in store, result register.
// ----------------------------------------------------------------------------
module mrd_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [7:0]            req_rx_byte,
   input  mrd_pkg::mrd_cmd_type  cmd,
   output mrd_pkg::mrd_stat_type stat,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_kind,
   output logic [7:0]            rsp_data_byte,
   output logic [1:0]            rsp_status,
   output logic [2:0]            rsp_baud_code,
   output logic                  rsp_block_end,
   output logic                  rsp_last
);

   localparam int BW = mrd_pkg::BLOCK_CNT_W;
   localparam int LW = mrd_pkg::LEAD_CNT_W;
   localparam int IW = mrd_pkg::LEAD_IDX_W;
   localparam int NW = mrd_pkg::IDENT_CNT_W;

   logic [7:0]  ch_ff, ch_in;
   logic [NW-1:0] ident_count_ff, ident_count_in;
   logic        line_bad_ff, line_bad_in;
   logic [7:0]  rate_ch_ff, rate_ch_in;
   logic        saw_etx_ff, saw_etx_in;
   logic [LW-1:0] lead_count_ff, lead_count_in;
   logic [LW-1:0] lead_idx_ff, lead_idx_in;
   logic [BW-1:0] block_count_ff, block_count_in;
   logic        lead_store_ff [mrd_pkg::LEAD_DEPTH];

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  kind_ff, kind_in;
   logic [7:0]  data_ff, data_in;
   logic [1:0]  status_ff, status_in;
   logic [2:0]  baud_ff, baud_in;
   logic        end_ff, end_in;
   logic        last_ff, last_in;

   logic        is_cr, is_lf, is_etx;
   logic        lead_room, lead_bit;
   logic [BW:0] open_total;
   logic [7:0]  baud_offset;

   assign is_cr       = (ch_ff == mrd_pkg::CH_CR);
   assign is_lf       = (ch_ff == mrd_pkg::CH_LF);
   assign is_etx      = (ch_ff == mrd_pkg::CH_ETX);
   assign lead_room   = (lead_count_ff < LW'(mrd_pkg::LEAD_DEPTH));
   assign lead_bit    = lead_store_ff[lead_idx_ff[IW-1:0]];
   assign open_total  = {1'b0, block_count_ff} + (BW+1)'(lead_count_ff) + (BW+1)'(1);
   assign baud_offset = rate_ch_ff - mrd_pkg::CH_ZERO;

   always_comb begin
      stat.is_slash   = (ch_ff == mrd_pkg::CH_SLASH);
      stat.is_lf      = is_lf;
      stat.is_crlf    = is_cr || is_lf;
      stat.is_stx     = (ch_ff == mrd_pkg::CH_STX);
      stat.is_print   = (ch_ff >= mrd_pkg::CH_SPACE) && (ch_ff <= mrd_pkg::CH_TILDE);
      stat.ident_room = (ident_count_ff < NW'(mrd_pkg::IDENT_LIMIT));
      stat.line_bad   = (ident_count_ff < NW'(mrd_pkg::MIN_IDENT_BYTES)) || line_bad_ff;
      stat.baud_ok    = (rate_ch_ff >= mrd_pkg::CH_ZERO) && (rate_ch_ff <= mrd_pkg::CH_SIX);
      stat.lead_more  = (lead_idx_ff < lead_count_ff);
      stat.too_big    = (open_total > (BW+1)'(mrd_pkg::MAX_BLOCK_BYTES));
      stat.block_full = (block_count_ff >= BW'(mrd_pkg::MAX_BLOCK_BYTES));
      stat.saw_etx    = saw_etx_ff;
      stat.slot_free  = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      ch_in          = cmd.ch_load ? req_rx_byte : ch_ff;
      ident_count_in = ident_count_ff;
      line_bad_in    = line_bad_ff;
      rate_ch_in     = rate_ch_ff;
      saw_etx_in     = saw_etx_ff;
      lead_count_in  = lead_count_ff;
      lead_idx_in    = lead_idx_ff;
      block_count_in = block_count_ff;
      priority if (cmd.clear) begin
         ident_count_in = '0;
         line_bad_in    = 1'b0;
         rate_ch_in     = '0;
         saw_etx_in     = 1'b0;
         lead_count_in  = '0;
         lead_idx_in    = '0;
         block_count_in = '0;
      end else if (cmd.ident_start) begin
         ident_count_in = '0;
         line_bad_in    = 1'b0;
         rate_ch_in     = '0;
      end else if (cmd.ident_take) begin
         if ((ident_count_ff >= NW'(1)) && (ident_count_ff <= NW'(3)) && (is_cr || is_lf))
            line_bad_in = 1'b1;
         if (ident_count_ff == NW'(4))
            rate_ch_in = ch_ff;
         ident_count_in = ident_count_ff + NW'(1);
      end else if (cmd.lead_push) begin
         if (lead_room)
            lead_count_in = lead_count_ff + LW'(1);
      end else if (cmd.lead_clear) begin
         lead_count_in = '0;
         lead_idx_in   = '0;
      end else if (cmd.lead_take) begin
         lead_idx_in    = lead_idx_ff + LW'(1);
         block_count_in = block_count_ff + BW'(1);
      end else if (cmd.block_take) begin
         block_count_in = block_count_ff + BW'(1);
         if (is_etx)
            saw_etx_in = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      kind_in      = kind_ff;
      data_in      = data_ff;
      status_in    = status_ff;
      baud_in      = baud_ff;
      end_in       = end_ff;
      last_in      = last_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         kind_in      = cmd.kind;
         status_in    = cmd.status;
         baud_in      = cmd.baud_en ? baud_offset[2:0] : 3'd0;
         end_in       = cmd.block_end;
         last_in      = cmd.last;
         unique case (cmd.data_sel)
            mrd_pkg::DSEL_RX:   data_in = ch_ff;
            mrd_pkg::DSEL_LEAD: data_in = lead_bit ? mrd_pkg::CH_LF : mrd_pkg::CH_CR;
            default:            data_in = 8'd0;
         endcase
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ident_count_ff <= '0;
         line_bad_ff    <= 1'b0;
         rate_ch_ff     <= '0;
         saw_etx_ff     <= 1'b0;
         lead_count_ff  <= '0;
         lead_idx_ff    <= '0;
         block_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         ident_count_ff <= ident_count_in;
         line_bad_ff    <= line_bad_in;
         rate_ch_ff     <= rate_ch_in;
         saw_etx_ff     <= saw_etx_in;
         lead_count_ff  <= lead_count_in;
         lead_idx_ff    <= lead_idx_in;
         block_count_ff <= block_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff     <= ch_in;
      kind_ff   <= kind_in;
      data_ff   <= data_in;
      status_ff <= status_in;
      baud_ff   <= baud_in;
      end_ff    <= end_in;
      last_ff   <= last_in;
      if (cmd.lead_push && lead_room)
         lead_store_ff[lead_count_ff[IW-1:0]] <= is_lf;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = kind_ff;
   assign rsp_data_byte = data_ff;
   assign rsp_status    = status_ff;
   assign rsp_baud_code = baud_ff;
   assign rsp_block_end = end_ff;
   assign rsp_last      = last_ff;

endmodule

/* hdl/meter_readout_deframer.sv */
// ----------------------------------------------------------------------------
// meter_readout_deframer - mode C readout receive deframer
// Finds the identification line, judges it and frames the data block.
// ----------------------------------------------------------------------------
// One received byte is taken per transfer on req_. The byte is taken, decoded
// and then gives its results in turn, when rsp_ready keeps the result register
// free; req_ready stays low until it is done. A byte without result gives none,
// a normal identification or block byte one, the closing LF of the identification
// line its byte and the verdict, and a printable byte that opens a block the
// buffered CR/LF bytes before its own. The result register drains on its own while the next byte is taken.
// Each input byte's final result carries rsp_last. The block check byte is
// passed on unchecked, flagged by rsp_block_end.
module meter_readout_deframer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_data_byte,
   output logic [1:0] rsp_status,
   output logic [2:0] rsp_baud_code,
   output logic       rsp_block_end,
   output logic       rsp_last
);

   mrd_pkg::mrd_cmd_type  cmd;
   mrd_pkg::mrd_stat_type stat;

   mrd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   mrd_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_rx_byte   (req_rx_byte),
      .cmd           (cmd),
      .stat          (stat),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_kind      (rsp_kind),
      .rsp_data_byte (rsp_data_byte),
      .rsp_status    (rsp_status),
      .rsp_baud_code (rsp_baud_code),
      .rsp_block_end (rsp_block_end),
      .rsp_last      (rsp_last)
   );

endmodule

/* hdl/mrd_checker.sv */
// ----------------------------------------------------------------------------
// mrd_checker - port-level checks for the deframer
// Result channel consistency rules, bound to the top level.
// ----------------------------------------------------------------------------
module mrd_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_kind,
   input logic [7:0] rsp_data_byte,
   input logic [1:0] rsp_status,
   input logic [2:0] rsp_baud_code,
   input logic       rsp_block_end,
   input logic       rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_data_byte)
         && $stable(rsp_status) && $stable(rsp_baud_code) && $stable(rsp_last))
      else $error("result changed while stalled");

   a_error_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == mrd_pkg::KIND_ERROR) |->
         rsp_last && (rsp_status == mrd_pkg::STATUS_BLOCK_LARGE) && (rsp_data_byte == 8'd0))
      else $error("malformed block error");

   a_bcc_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_block_end |-> rsp_last && (rsp_kind == mrd_pkg::KIND_BLOCK))
      else $error("check byte not final block result");

   a_data_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_kind == mrd_pkg::KIND_IDENT) || (rsp_kind == mrd_pkg::KIND_BLOCK)) |->
         (rsp_status == mrd_pkg::STATUS_OK) && (rsp_baud_code == 3'd0))
      else $error("data result with status");

   a_verdict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == mrd_pkg::KIND_VERDICT) |->
         rsp_last && !rsp_block_end
         && ((rsp_status == mrd_pkg::STATUS_OK) || (rsp_baud_code == 3'd0)))
      else $error("malformed verdict");

endmodule

bind meter_readout_deframer mrd_checker u_mrd_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_kind      (rsp_kind),
   .rsp_data_byte (rsp_data_byte),
   .rsp_status    (rsp_status),
   .rsp_baud_code (rsp_baud_code),
   .rsp_block_end (rsp_block_end),
   .rsp_last      (rsp_last)
);
